/* sv/jda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog dead-man axis controller package
// Shared widths, operation codes, register indexes, frame types and helpers.
// ----------------------------------------------------------------------------
package jda_pkg;

   localparam int AXIS_COUNT_DEFAULT = 3;

   localparam int OP_W          = 2;
   localparam int AXIS_W        = 2;
   localparam int SPEED_W       = 16;
   localparam int SPEED_LIMIT_W = 15;
   localparam int GEAR_W        = 8;
   localparam int LEVEL_W       = 7;
   localparam int TICK_W        = 16;
   localparam int OPCODE_W      = 10;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int SLOT_COUNT    = 3;
   localparam int SLOT_W        = 2;

   // input operation codes
   typedef enum logic [OP_W-1:0] {
      OP_SET      = 2'd0,
      OP_STOP     = 2'd1,
      OP_STOP_ALL = 2'd2,
      OP_TICK     = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_FLOOR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_CEILING = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_FLOOR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_CEILING = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEASE_TICKS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_TICKS  = 3'd5;

   // configuration reset values
   localparam logic [SPEED_LIMIT_W-1:0] SPEED_FLOOR_RESET   = 15'd1;
   localparam logic [SPEED_LIMIT_W-1:0] SPEED_CEILING_RESET = 15'd100;
   localparam logic [LEVEL_W-1:0]       LEVEL_FLOOR_RESET   = 7'd1;
   localparam logic [LEVEL_W-1:0]       LEVEL_CEILING_RESET = 7'd5;
   localparam logic [TICK_W-1:0]        LEASE_TICKS_RESET   = 16'd1000;
   localparam logic [TICK_W-1:0]        REPEAT_TICKS_RESET  = 16'd100;

   // frame kinds
   localparam logic KIND_FAST = 1'b0;
   localparam logic KIND_SLOW = 1'b1;

   // command opcodes per axis
   localparam logic [OPCODE_W-1:0] OPCODE_FAST_PAN    = 10'd513;
   localparam logic [OPCODE_W-1:0] OPCODE_FAST_TILT   = 10'd514;
   localparam logic [OPCODE_W-1:0] OPCODE_FAST_ROTATE = 10'd521;
   localparam logic [OPCODE_W-1:0] OPCODE_SLOW_PAN    = 10'd532;
   localparam logic [OPCODE_W-1:0] OPCODE_SLOW_TILT   = 10'd533;
   localparam logic [OPCODE_W-1:0] OPCODE_SLOW_ROTATE = 10'd534;

   localparam logic [AXIS_W-1:0] AXIS_PAN    = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_TILT   = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_ROTATE = 2'd2;

   // one command frame as planned by the datapath
   typedef struct packed {
      logic                      kind;
      logic signed [SPEED_W-1:0] speed;
      logic signed [GEAR_W-1:0]  gear;
      logic                      press;
   } frame_type;

   // controller to datapath commands
   typedef struct packed {
      logic              load;
      logic              emit_frame;
      logic [SLOT_W-1:0] slot;
      logic              commit;
      logic              emit_status;
      logic [AXIS_W-1:0] axis;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [SLOT_COUNT-1:0] slot_valid;
   } dp_status_type;

   function automatic logic [SPEED_W-1:0] clamp_mag(input logic [SPEED_W-1:0] v,
                                                    input logic [SPEED_W-1:0] lo,
                                                    input logic [SPEED_W-1:0] hi);
      logic [SPEED_W-1:0] r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   function automatic logic [OPCODE_W-1:0] opcode_for(input logic kind,
                                                      input logic [AXIS_W-1:0] axis);
      logic [OPCODE_W-1:0] code;
      case (axis)
         AXIS_PAN:    code = (kind == KIND_SLOW) ? OPCODE_SLOW_PAN : OPCODE_FAST_PAN;
         AXIS_TILT:   code = (kind == KIND_SLOW) ? OPCODE_SLOW_TILT : OPCODE_FAST_TILT;
         AXIS_ROTATE: code = (kind == KIND_SLOW) ? OPCODE_SLOW_ROTATE : OPCODE_FAST_ROTATE;
         default:     code = '0;
      endcase
      return code;
   endfunction

   function automatic frame_type fast_frame(input logic signed [SPEED_W-1:0] speed);
      frame_type f;
      f.kind  = KIND_FAST;
      f.speed = speed;
      f.gear  = '0;
      f.press = 1'b0;
      return f;
   endfunction

   function automatic frame_type slow_frame(input logic signed [GEAR_W-1:0] gear,
                                            input logic press);
      frame_type f;
      f.kind  = KIND_SLOW;
      f.speed = '0;
      f.gear  = gear;
      f.press = press;
      return f;
   endfunction

endpackage

/* sv/jda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog controller sequencer
// Walks the axes one by one, steps through each axis's frame slots, commits
// the axis state and closes every item with the status item.
// ----------------------------------------------------------------------------
module jda_ctrl #(
   parameter int AXIS_COUNT = jda_pkg::AXIS_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  jda_pkg::dp_status_type  dp_status,
   output jda_pkg::ctrl_cmd_type   cmd
);

   localparam logic [jda_pkg::AXIS_W-1:0] LAST_AXIS = jda_pkg::AXIS_W'(AXIS_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_STATUS
   } state_type;

   state_type                     state_ff, state_in;
   logic [jda_pkg::AXIS_W-1:0]    idx_ff, idx_in;
   logic [jda_pkg::SLOT_W-1:0]    phase_ff, phase_in;
   logic                          busy_ff, busy_in;
   logic                          slot_here;
   logic                          slot_above;

   // slot under the phase, and any slot still to come for this axis
   always_comb begin
      slot_here  = 1'b0;
      slot_above = 1'b0;
      case (phase_ff)
         2'd0: begin
            slot_here  = dp_status.slot_valid[0];
            slot_above = dp_status.slot_valid[1] | dp_status.slot_valid[2];
         end
         2'd1: begin
            slot_here  = dp_status.slot_valid[1];
            slot_above = dp_status.slot_valid[2];
         end
         2'd2: begin
            slot_here  = dp_status.slot_valid[2];
         end
         default: begin
            slot_here  = 1'b0;
         end
      endcase
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      phase_in        = phase_ff;
      busy_in         = busy_ff;
      cmd             = '0;
      cmd.axis        = idx_ff;
      cmd.slot        = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_WALK;
               idx_in   = '0;
               phase_in = '0;
               busy_in  = 1'b1;
            end
         end
         ST_WALK: begin
            cmd.emit_frame = slot_here;
            cmd.commit     = !slot_above;
            if (slot_above) begin
               phase_in = phase_ff + 1'b1;
            end else begin
               phase_in = '0;
               if (idx_ff == LAST_AXIS) state_in = ST_STATUS;
               else idx_in = idx_ff + 1'b1;
            end
         end
         ST_STATUS: begin
            cmd.emit_status = 1'b1;
            state_in        = ST_IDLE;
            busy_in         = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         phase_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/jda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog controller datapath
// Holds configuration, the latched item and per-axis state; plans the frames
// of one axis, commits its next state and drives the result register.
// ----------------------------------------------------------------------------
module jda_datapath #(
   parameter int AXIS_COUNT = jda_pkg::AXIS_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write,
   input  logic [jda_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [jda_pkg::CSR_DATA_W-1:0]         csr_wdata,
   // item fields
   input  logic [jda_pkg::OP_W-1:0]               req_operation,
   input  logic [jda_pkg::AXIS_W-1:0]             req_axis_index,
   input  logic signed [jda_pkg::SPEED_W-1:0]     req_speed_request,
   input  logic signed [jda_pkg::GEAR_W-1:0]      req_gear_request,
   input  logic                                   req_link_up,
   // sequencer link
   input  jda_pkg::ctrl_cmd_type                  cmd,
   output jda_pkg::dp_status_type                 dp_status,
   // result
   output logic                                   rsp_valid,
   output logic                                   rsp_is_frame,
   output logic [jda_pkg::OPCODE_W-1:0]           rsp_opcode,
   output logic                                   rsp_frame_kind,
   output logic signed [jda_pkg::SPEED_W-1:0]     rsp_speed_value,
   output logic                                   rsp_direction_key,
   output logic                                   rsp_press_state,
   output logic [jda_pkg::LEVEL_W-1:0]            rsp_level,
   output logic                                   rsp_accepted,
   output logic                                   rsp_any_active,
   output logic                                   rsp_deadline_valid,
   output logic [jda_pkg::TICK_W-1:0]             rsp_deadline_ticks,
   output logic                                   rsp_last
);

   localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int SW    = jda_pkg::SPEED_W;
   localparam int GW    = jda_pkg::GEAR_W;
   localparam int TW    = jda_pkg::TICK_W;
   localparam int LW    = jda_pkg::LEVEL_W;

   // configuration registers
   logic [jda_pkg::SPEED_LIMIT_W-1:0] speed_floor_ff, speed_ceiling_ff;
   logic [LW-1:0]                     level_floor_ff, level_ceiling_ff;
   logic [TW-1:0]                     lease_ticks_ff, repeat_ticks_ff;

   // latched item
   jda_pkg::op_type                   op_ff;
   logic [jda_pkg::AXIS_W-1:0]        axis_ff;
   logic signed [SW-1:0]              speed_req_ff;
   logic signed [GW-1:0]              gear_req_ff;
   logic                              link_ff;

   // per-axis state
   logic signed [SW-1:0]              speed_ff   [AXIS_COUNT];
   logic signed [GW-1:0]              gear_ff    [AXIS_COUNT];
   logic                              pressed_ff [AXIS_COUNT];
   logic [TW-1:0]                     lease_ff   [AXIS_COUNT];
   logic [TW-1:0]                     repeat_ff  [AXIS_COUNT];

   // current axis view and plan
   logic [IDX_W-1:0]                  cur;
   logic signed [SW-1:0]              cur_speed;
   logic signed [GW-1:0]              cur_gear;
   logic                              cur_pressed;
   logic [TW-1:0]                     cur_lease, cur_repeat;
   logic                              cur_active, selected, zero_req;
   logic [TW-1:0]                     lease_dec, repeat_dec;
   logic [SW-1:0]                     speed_mag, speed_clamped;
   logic signed [SW-1:0]              speed_want;
   logic                              stop_it, clear_it;
   jda_pkg::frame_type                slot_frame [jda_pkg::SLOT_COUNT];
   logic [jda_pkg::SLOT_COUNT-1:0]    slot_valid;
   logic signed [SW-1:0]              speed_in;
   logic signed [GW-1:0]              gear_in;
   logic                              pressed_in;
   logic [TW-1:0]                     lease_in, repeat_in;

   // emitted frame and status
   jda_pkg::frame_type                fr;
   logic [GW-1:0]                     gear_mag;
   logic [SW-1:0]                     level_wide;
   logic                              accept_flag, valid_axis;
   logic                              active_any;
   logic [TW-1:0]                     best, cand;

   // result register
   logic                              rsp_valid_ff;
   logic                              is_frame_ff, frame_kind_ff, direction_ff, press_ff;
   logic [jda_pkg::OPCODE_W-1:0]      opcode_ff;
   logic signed [SW-1:0]              speed_value_ff;
   logic [LW-1:0]                     level_ff;
   logic                              accepted_ff, any_active_ff, deadline_valid_ff, last_ff;
   logic [TW-1:0]                     deadline_ticks_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_floor_ff   <= jda_pkg::SPEED_FLOOR_RESET;
         speed_ceiling_ff <= jda_pkg::SPEED_CEILING_RESET;
         level_floor_ff   <= jda_pkg::LEVEL_FLOOR_RESET;
         level_ceiling_ff <= jda_pkg::LEVEL_CEILING_RESET;
         lease_ticks_ff   <= jda_pkg::LEASE_TICKS_RESET;
         repeat_ticks_ff  <= jda_pkg::REPEAT_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            jda_pkg::CSR_SPEED_FLOOR:
               speed_floor_ff <= csr_wdata[jda_pkg::SPEED_LIMIT_W-1:0];
            jda_pkg::CSR_SPEED_CEILING:
               speed_ceiling_ff <= csr_wdata[jda_pkg::SPEED_LIMIT_W-1:0];
            jda_pkg::CSR_LEVEL_FLOOR:   level_floor_ff   <= csr_wdata[LW-1:0];
            jda_pkg::CSR_LEVEL_CEILING: level_ceiling_ff <= csr_wdata[LW-1:0];
            jda_pkg::CSR_LEASE_TICKS:   lease_ticks_ff   <= csr_wdata[TW-1:0];
            jda_pkg::CSR_REPEAT_TICKS:  repeat_ticks_ff  <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   // latch the item on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= jda_pkg::op_type'(req_operation);
         axis_ff      <= req_axis_index;
         speed_req_ff <= req_speed_request;
         gear_req_ff  <= req_gear_request;
         link_ff      <= req_link_up;
      end
   end

   // read the axis under work
   assign cur         = cmd.axis[IDX_W-1:0];
   assign cur_speed   = speed_ff[cur];
   assign cur_gear    = gear_ff[cur];
   assign cur_pressed = pressed_ff[cur];
   assign cur_lease   = lease_ff[cur];
   assign cur_repeat  = repeat_ff[cur];
   assign cur_active  = cur_pressed || (cur_speed != '0);
   assign selected    = (axis_ff == cmd.axis);
   assign zero_req    = (speed_req_ff == '0) && (gear_req_ff == '0);
   assign lease_dec   = (cur_lease != '0) ? cur_lease - 1'b1 : '0;
   assign repeat_dec  = (cur_repeat != '0) ? cur_repeat - 1'b1 : '0;

   // requested fast speed, magnitude clamped, sign kept
   assign speed_mag     = speed_req_ff[SW-1] ? SW'(-speed_req_ff) : SW'(speed_req_ff);
   assign speed_clamped = jda_pkg::clamp_mag(speed_mag, SW'(speed_floor_ff),
                                             SW'(speed_ceiling_ff));
   assign speed_want    = speed_req_ff[SW-1] ? -$signed(speed_clamped)
                                             : $signed(speed_clamped);

   // frame plan and next state of the current axis
   always_comb begin
      stop_it    = 1'b0;
      clear_it   = 1'b0;
      slot_valid = '0;
      for (int s = 0; s < jda_pkg::SLOT_COUNT; s++) begin
         slot_frame[s] = jda_pkg::fast_frame('0);
      end
      speed_in   = cur_speed;
      gear_in    = cur_gear;
      pressed_in = cur_pressed;
      lease_in   = cur_lease;
      repeat_in  = cur_repeat;
      unique case (op_ff)
         jda_pkg::OP_SET: begin
            if (selected) begin
               if (zero_req) begin
                  stop_it = 1'b1;
               end else if (link_ff) begin
                  if (speed_req_ff != '0) begin
                     // leave slow mode, then send the new speed if it changed
                     slot_frame[0] = jda_pkg::slow_frame(cur_gear, 1'b0);
                     slot_valid[0] = cur_pressed;
                     pressed_in    = 1'b0;
                     if (cur_pressed) gear_in = '0;
                     if (cur_speed != speed_want) begin
                        slot_frame[1] = jda_pkg::fast_frame(speed_want);
                        slot_valid[1] = 1'b1;
                        speed_in      = speed_want;
                        repeat_in     = repeat_ticks_ff;
                     end
                     lease_in = lease_ticks_ff;
                  end else begin
                     // stop fast motion, then re-press at the new gear
                     slot_frame[0] = jda_pkg::fast_frame('0);
                     slot_valid[0] = (cur_speed != '0);
                     speed_in      = '0;
                     if (!cur_pressed || (cur_gear != gear_req_ff)) begin
                        slot_frame[1] = jda_pkg::slow_frame(cur_gear, 1'b0);
                        slot_valid[1] = cur_pressed;
                        slot_frame[2] = jda_pkg::slow_frame(gear_req_ff, 1'b1);
                        slot_valid[2] = 1'b1;
                        gear_in       = gear_req_ff;
                        pressed_in    = 1'b1;
                     end
                     lease_in  = lease_ticks_ff;
                     repeat_in = '0;
                  end
               end
            end
         end
         jda_pkg::OP_STOP: begin
            stop_it = selected;
         end
         jda_pkg::OP_STOP_ALL: begin
            stop_it = 1'b1;
         end
         jda_pkg::OP_TICK: begin
            if (!link_ff) begin
               clear_it = 1'b1;
            end else if (cur_active) begin
               if (lease_dec == '0) begin
                  stop_it = 1'b1;
               end else begin
                  lease_in  = lease_dec;
                  repeat_in = repeat_dec;
                  if ((cur_speed != '0) && (repeat_dec == '0)) begin
                     slot_frame[0] = jda_pkg::fast_frame(cur_speed);
                     slot_valid[0] = 1'b1;
                     repeat_in     = repeat_ticks_ff;
                  end
               end
            end
         end
      endcase
      // stop: release the press, then zero the speed
      if (stop_it) begin
         slot_frame[0] = jda_pkg::slow_frame(cur_gear, 1'b0);
         slot_valid[0] = cur_pressed;
         slot_frame[1] = jda_pkg::fast_frame('0);
         slot_valid[1] = (cur_speed != '0);
         slot_frame[2] = jda_pkg::fast_frame('0);
         slot_valid[2] = 1'b0;
      end
      if (stop_it || clear_it) begin
         speed_in   = '0;
         gear_in    = '0;
         pressed_in = 1'b0;
         lease_in   = '0;
         repeat_in  = '0;
      end
   end

   assign dp_status.slot_valid = slot_valid;

   // per-axis state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            speed_ff[a]   <= '0;
            gear_ff[a]    <= '0;
            pressed_ff[a] <= 1'b0;
            lease_ff[a]   <= '0;
            repeat_ff[a]  <= '0;
         end
      end else if (cmd.commit) begin
         speed_ff[cur]   <= speed_in;
         gear_ff[cur]    <= gear_in;
         pressed_ff[cur] <= pressed_in;
         lease_ff[cur]   <= lease_in;
         repeat_ff[cur]  <= repeat_in;
      end
   end

   // frame fields of the emitted slot
   assign fr         = slot_frame[cmd.slot];
   assign gear_mag   = fr.gear[GW-1] ? GW'(-fr.gear) : GW'(fr.gear);
   assign level_wide = jda_pkg::clamp_mag(SW'(gear_mag), SW'(level_floor_ff),
                                          SW'(level_ceiling_ff));

   // status: acceptance and the nearest deadline over active axes
   assign valid_axis = (int'(axis_ff) < AXIS_COUNT);
   always_comb begin
      unique case (op_ff)
         jda_pkg::OP_SET:      accept_flag = valid_axis && (zero_req || link_ff);
         jda_pkg::OP_STOP:     accept_flag = valid_axis;
         jda_pkg::OP_STOP_ALL: accept_flag = 1'b1;
         jda_pkg::OP_TICK:     accept_flag = link_ff;
      endcase
   end

   always_comb begin
      active_any = 1'b0;
      best       = '0;
      cand       = '0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (pressed_ff[a] || (speed_ff[a] != '0)) begin
            cand = lease_ff[a];
            if ((speed_ff[a] != '0) && (repeat_ff[a] < cand)) cand = repeat_ff[a];
            if (!active_any || (cand < best)) best = cand;
            active_any = 1'b1;
         end
      end
   end

   // result register: one item per strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.emit_frame | cmd.emit_status;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_frame) begin
         is_frame_ff       <= 1'b1;
         opcode_ff         <= jda_pkg::opcode_for(fr.kind, cmd.axis);
         frame_kind_ff     <= fr.kind;
         speed_value_ff    <= (fr.kind == jda_pkg::KIND_FAST) ? fr.speed : '0;
         direction_ff      <= (fr.kind == jda_pkg::KIND_SLOW) && fr.gear[GW-1];
         press_ff          <= (fr.kind == jda_pkg::KIND_SLOW) && fr.press;
         level_ff          <= (fr.kind == jda_pkg::KIND_SLOW) ? level_wide[LW-1:0] : '0;
         accepted_ff       <= 1'b0;
         any_active_ff     <= 1'b0;
         deadline_valid_ff <= 1'b0;
         deadline_ticks_ff <= '0;
         last_ff           <= 1'b0;
      end else if (cmd.emit_status) begin
         is_frame_ff       <= 1'b0;
         opcode_ff         <= '0;
         frame_kind_ff     <= 1'b0;
         speed_value_ff    <= '0;
         direction_ff      <= 1'b0;
         press_ff          <= 1'b0;
         level_ff          <= '0;
         accepted_ff       <= accept_flag;
         any_active_ff     <= active_any;
         deadline_valid_ff <= active_any;
         deadline_ticks_ff <= best;
         last_ff           <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_frame       = is_frame_ff;
   assign rsp_opcode         = opcode_ff;
   assign rsp_frame_kind     = frame_kind_ff;
   assign rsp_speed_value    = speed_value_ff;
   assign rsp_direction_key  = direction_ff;
   assign rsp_press_state    = press_ff;
   assign rsp_level          = level_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_any_active     = any_active_ff;
   assign rsp_deadline_valid = deadline_valid_ff;
   assign rsp_deadline_ticks = deadline_ticks_ff;
   assign rsp_last           = last_ff;

endmodule

/* sv/jog_deadman_axis_controller.sv */
`timescale 1ns / 1ps
// Results follow a taken start through the sequencer's axis walk and the result register;
// a frame slot with no frame gives no result, so results can have gaps. No new start
// is taken until the sequencer has walked every axis and sent the status item; busy is high meanwhile.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (synchronous, active high) clears all axes and restores register defaults.
// ----------------------------------------------------------------------------
// Jog dead-man axis controller
// Per-axis fast/slow jog control with lease expiry and fast-frame repeat.
// ----------------------------------------------------------------------------
module jog_deadman_axis_controller #(
   parameter int AXIS_COUNT = jda_pkg::AXIS_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [jda_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [jda_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [jda_pkg::OP_W-1:0]               req_operation,
   input  logic [jda_pkg::AXIS_W-1:0]             req_axis_index,
   input  logic signed [jda_pkg::SPEED_W-1:0]     req_speed_request,
   input  logic signed [jda_pkg::GEAR_W-1:0]      req_gear_request,
   input  logic                                   req_link_up,
   output logic                                   rsp_valid,
   output logic                                   rsp_is_frame,
   output logic [jda_pkg::OPCODE_W-1:0]           rsp_opcode,
   output logic                                   rsp_frame_kind,
   output logic signed [jda_pkg::SPEED_W-1:0]     rsp_speed_value,
   output logic                                   rsp_direction_key,
   output logic                                   rsp_press_state,
   output logic [jda_pkg::LEVEL_W-1:0]            rsp_level,
   output logic                                   rsp_accepted,
   output logic                                   rsp_any_active,
   output logic                                   rsp_deadline_valid,
   output logic [jda_pkg::TICK_W-1:0]             rsp_deadline_ticks,
   output logic                                   rsp_last
);

   jda_pkg::ctrl_cmd_type  cmd;
   jda_pkg::dp_status_type dp_status;

   // sequencer
   jda_ctrl #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // datapath
   jda_datapath #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_operation      (req_operation),
      .req_axis_index     (req_axis_index),
      .req_speed_request  (req_speed_request),
      .req_gear_request   (req_gear_request),
      .req_link_up        (req_link_up),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .rsp_valid          (rsp_valid),
      .rsp_is_frame       (rsp_is_frame),
      .rsp_opcode         (rsp_opcode),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_speed_value    (rsp_speed_value),
      .rsp_direction_key  (rsp_direction_key),
      .rsp_press_state    (rsp_press_state),
      .rsp_level          (rsp_level),
      .rsp_accepted       (rsp_accepted),
      .rsp_any_active     (rsp_any_active),
      .rsp_deadline_valid (rsp_deadline_valid),
      .rsp_deadline_ticks (rsp_deadline_ticks),
      .rsp_last           (rsp_last)
   );

endmodule

/* dv/jog_deadman_axis_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog dead-man axis controller testbench
// Drives set, stop, stop-all and tick commands through the start/busy port.
// A scoreboard tracks every axis, predicts the frames and the closing status
// item of each command, and checks every strobed output against them.
// ----------------------------------------------------------------------------
module jog_deadman_axis_controller_tb;
   import jda_pkg::*;

   localparam int AXES        = AXIS_COUNT_DEFAULT;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 80;
   localparam int PHASES      = 6;

   // one output item as seen on the rsp_ ports
   typedef struct packed {
      logic                      is_frame;
      logic [OPCODE_W-1:0]       opcode;
      logic                      frame_kind;
      logic signed [SPEED_W-1:0] speed_value;
      logic                      direction_key;
      logic                      press_state;
      logic [LEVEL_W-1:0]        level;
      logic                      accepted;
      logic                      any_active;
      logic                      deadline_valid;
      logic [TICK_W-1:0]         deadline_ticks;
      logic                      last;
   } jog_output_t;

   // axis state mirror, frame prediction and output checking
   class jog_scoreboard;
      logic [SPEED_LIMIT_W-1:0]  speed_floor, speed_ceiling;
      logic [LEVEL_W-1:0]        level_floor, level_ceiling;
      logic [TICK_W-1:0]         lease_ticks, repeat_ticks;
      logic signed [SPEED_W-1:0] speed_held[AXES];
      logic signed [GEAR_W-1:0]  gear_held[AXES];
      bit                        pressed[AXES];
      logic [TICK_W-1:0]         lease_left[AXES];
      logic [TICK_W-1:0]         repeat_left[AXES];
      logic [OPCODE_W-1:0]       fast_code[3];
      logic [OPCODE_W-1:0]       slow_code[3];
      jog_output_t               predicted[$];
      int commands, checked, frames, expiries, repeats, errors;

      function new();
         fast_code = '{OPCODE_FAST_PAN, OPCODE_FAST_TILT, OPCODE_FAST_ROTATE};
         slow_code = '{OPCODE_SLOW_PAN, OPCODE_SLOW_TILT, OPCODE_SLOW_ROTATE};
         speed_floor   = SPEED_FLOOR_RESET;
         speed_ceiling = SPEED_CEILING_RESET;
         level_floor   = LEVEL_FLOOR_RESET;
         level_ceiling = LEVEL_CEILING_RESET;
         lease_ticks   = LEASE_TICKS_RESET;
         repeat_ticks  = REPEAT_TICKS_RESET;
         clear_axes();
      endfunction

      function void clear_axes();
         for (int i = 0; i < AXES; i++) begin
            speed_held[i]  = '0;
            gear_held[i]   = '0;
            pressed[i]     = 1'b0;
            lease_left[i]  = '0;
            repeat_left[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SPEED_FLOOR:   speed_floor   = data[SPEED_LIMIT_W-1:0];
            CSR_SPEED_CEILING: speed_ceiling = data[SPEED_LIMIT_W-1:0];
            CSR_LEVEL_FLOOR:   level_floor   = data[LEVEL_W-1:0];
            CSR_LEVEL_CEILING: level_ceiling = data[LEVEL_W-1:0];
            CSR_LEASE_TICKS:   lease_ticks   = data;
            CSR_REPEAT_TICKS:  repeat_ticks  = data;
            default: ;
         endcase
      endfunction

      // floor first; if floor > ceiling, values under it give the floor, others the ceiling
      function int bound(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void push_fast(int a, int spd);
         jog_output_t r;
         r = '0;
         r.is_frame    = 1'b1;
         r.opcode      = fast_code[a];
         r.frame_kind  = KIND_FAST;
         r.speed_value = spd;
         predicted.push_back(r);
         frames++;
      endfunction

      function void push_slow(int a, int gear, bit press);
         jog_output_t r;
         int mag;
         mag = (gear < 0) ? -gear : gear;
         r = '0;
         r.is_frame      = 1'b1;
         r.opcode        = slow_code[a];
         r.frame_kind    = KIND_SLOW;
         r.direction_key = (gear < 0);
         r.press_state   = press;
         r.level         = bound(mag, level_floor, level_ceiling);
         predicted.push_back(r);
         frames++;
      endfunction

      function bit axis_active(int a);
         return pressed[a] || speed_held[a] != 0;
      endfunction

      function void stop_axis(int a);
         if (pressed[a]) begin
            push_slow(a, gear_held[a], 1'b0);
            pressed[a] = 1'b0;
         end
         if (speed_held[a] != 0) begin
            push_fast(a, 0);
            speed_held[a] = '0;
         end
         gear_held[a]   = '0;
         lease_left[a]  = '0;
         repeat_left[a] = '0;
      endfunction

      function bit apply_set(int a, int spd, int gear, bit link);
         int mag, c, want;
         // an all-zero request is a stop, link or not
         if (spd == 0 && gear == 0) begin
            stop_axis(a);
            return 1'b1;
         end
         if (!link) return 1'b0;
         if (spd != 0) begin
            mag  = (spd < 0) ? -spd : spd;
            c    = bound(mag, speed_floor, speed_ceiling);
            want = (spd < 0) ? -c : c;
            if (pressed[a]) begin
               push_slow(a, gear_held[a], 1'b0);
               pressed[a]   = 1'b0;
               gear_held[a] = '0;
            end
            // same speed only renews the lease
            if (speed_held[a] != want) begin
               speed_held[a] = want;
               push_fast(a, want);
               repeat_left[a] = repeat_ticks;
            end
            lease_left[a] = lease_ticks;
            return 1'b1;
         end
         // slow latched press
         if (speed_held[a] != 0) begin
            push_fast(a, 0);
            speed_held[a] = '0;
         end
         if (!pressed[a] || gear_held[a] != gear) begin
            if (pressed[a]) push_slow(a, gear_held[a], 1'b0);
            gear_held[a] = gear;
            push_slow(a, gear, 1'b1);
            pressed[a] = 1'b1;
         end
         lease_left[a]  = lease_ticks;
         repeat_left[a] = '0;
         return 1'b1;
      endfunction

      function void advance_tick();
         for (int i = 0; i < AXES; i++) begin
            if (!axis_active(i)) continue;
            if (lease_left[i] > 0) lease_left[i]--;
            if (repeat_left[i] > 0) repeat_left[i]--;
            // lease is checked before the repeat
            if (lease_left[i] == 0) begin
               stop_axis(i);
               expiries++;
               continue;
            end
            if (speed_held[i] != 0 && repeat_left[i] == 0) begin
               push_fast(i, speed_held[i]);
               repeat_left[i] = repeat_ticks;
               repeats++;
            end
         end
      endfunction

      // accepted command: predict its frames and closing status item
      function void note_command(op_type op, logic [AXIS_W-1:0] ax,
                                 logic signed [SPEED_W-1:0] spd,
                                 logic signed [GEAR_W-1:0] gear, logic link);
         jog_output_t st;
         bit acc, any, dvalid;
         int best, d;
         acc = 1'b0;
         any = 1'b0;
         dvalid = 1'b0;
         best = 0;
         commands++;
         case (op)
            OP_SET:
               if (ax < AXES) acc = apply_set(ax, spd, gear, link);
            OP_STOP:
               if (ax < AXES) begin
                  stop_axis(ax);
                  acc = 1'b1;
               end
            OP_STOP_ALL: begin
               for (int i = 0; i < AXES; i++) stop_axis(i);
               acc = 1'b1;
            end
            OP_TICK:
               if (!link) clear_axes();
               else begin
                  advance_tick();
                  acc = 1'b1;
               end
            default: ;
         endcase
         // nearest lease expiry or repeat among active axes
         for (int i = 0; i < AXES; i++) begin
            if (!axis_active(i)) continue;
            any = 1'b1;
            d = lease_left[i];
            if (speed_held[i] != 0 && repeat_left[i] < d) d = repeat_left[i];
            if (!dvalid || d < best) best = d;
            dvalid = 1'b1;
         end
         st = '0;
         st.accepted       = acc;
         st.any_active     = any;
         st.deadline_valid = dvalid;
         st.deadline_ticks = best;
         st.last           = 1'b1;
         predicted.push_back(st);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_output(jog_output_t got);
         jog_output_t want;
         if (predicted.size() == 0) begin
            $display("%0t: unexpected output, expected none, actual opcode %0d last %0d",
                     $time, got.opcode, got.last);
            errors++;
            return;
         end
         want = predicted.pop_front();
         checked++;
         compare_field("is_frame", want.is_frame, got.is_frame);
         compare_field("opcode", want.opcode, got.opcode);
         compare_field("frame_kind", want.frame_kind, got.frame_kind);
         compare_field("speed_value", want.speed_value, got.speed_value);
         compare_field("direction_key", want.direction_key, got.direction_key);
         compare_field("press_state", want.press_state, got.press_state);
         compare_field("level", want.level, got.level);
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("any_active", want.any_active, got.any_active);
         compare_field("deadline_valid", want.deadline_valid, got.deadline_valid);
         compare_field("deadline_ticks", want.deadline_ticks, got.deadline_ticks);
         compare_field("last", want.last, got.last);
      endfunction

      function int outstanding();
         return predicted.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_write;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   logic                       start;
   logic                       busy;
   logic [OP_W-1:0]            req_operation;
   logic [AXIS_W-1:0]          req_axis_index;
   logic signed [SPEED_W-1:0]  req_speed_request;
   logic signed [GEAR_W-1:0]   req_gear_request;
   logic                       req_link_up;
   logic                       rsp_valid;
   jog_output_t                seen;
   jog_output_t                rsp_bus;

   jog_scoreboard sb;
   int taken;
   int stall_cycles;
   int last_fast_req[AXES];

   jog_deadman_axis_controller i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_axis_index     (req_axis_index),
      .req_speed_request  (req_speed_request),
      .req_gear_request   (req_gear_request),
      .req_link_up        (req_link_up),
      .rsp_valid          (rsp_valid),
      .rsp_is_frame       (rsp_bus.is_frame),
      .rsp_opcode         (rsp_bus.opcode),
      .rsp_frame_kind     (rsp_bus.frame_kind),
      .rsp_speed_value    (rsp_bus.speed_value),
      .rsp_direction_key  (rsp_bus.direction_key),
      .rsp_press_state    (rsp_bus.press_state),
      .rsp_level          (rsp_bus.level),
      .rsp_accepted       (rsp_bus.accepted),
      .rsp_any_active     (rsp_bus.any_active),
      .rsp_deadline_valid (rsp_bus.deadline_valid),
      .rsp_deadline_ticks (rsp_bus.deadline_ticks),
      .rsp_last           (rsp_bus.last)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // outputs first, then the item taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            seen = rsp_bus;
            sb.check_output(seen);
         end
         if (start && !busy) begin
            sb.note_command(op_type'(req_operation), req_axis_index, req_speed_request,
                            req_gear_request, req_link_up);
            taken++;
         end
      end
   end

   // watchdog: cycles with neither an item taken nor an output strobed
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((!reset && start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("watchdog: no progress for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("TB_ERROR");
      $finish;
   end

   // present one command, return at the falling edge after it is taken
   task automatic send_command(input op_type op, input logic [AXIS_W-1:0] ax,
                               input logic signed [SPEED_W-1:0] spd,
                               input logic signed [GEAR_W-1:0] gear,
                               input logic link, input int gap);
      int n;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation     <= op;
      req_axis_index    <= ax;
      req_speed_request <= spd;
      req_gear_request  <= gear;
      req_link_up       <= link;
      start             <= 1'b1;
      n = taken;
      do @(negedge clock); while (taken == n);
   endtask

   // wait for every predicted output, then let the block settle
   task automatic drain();
      start <= 1'b0;
      while (sb.outstanding() != 0 || busy) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_regs(input int sf, input int sc, input int lf, input int lc,
                               input int lt, input int rt);
      write_reg(CSR_SPEED_FLOOR, sf);
      write_reg(CSR_SPEED_CEILING, sc);
      write_reg(CSR_LEVEL_FLOOR, lf);
      write_reg(CSR_LEVEL_CEILING, lc);
      write_reg(CSR_LEASE_TICKS, lt);
      write_reg(CSR_REPEAT_TICKS, rt);
   endtask

   // mostly valid jog traffic on live axes, with some noise
   task automatic random_command(input int idle_pct);
      op_type op;
      int pick, kind, r, ax, spd, gear, gap;
      logic link;
      pick = $urandom_range(99);
      ax   = ($urandom_range(99) < 6) ? 3 : $urandom_range(AXES - 1);
      link = ($urandom_range(99) < 5) ? 1'b0 : 1'b1;
      spd  = $urandom;
      gear = $urandom;
      if (pick < 42) begin
         op   = OP_SET;
         kind = $urandom_range(99);
         r    = $urandom_range(99);
         if (kind < 10) begin
            spd  = 0;
            gear = 0;
         end else if (kind < 55) begin
            if (r < 25 && ax < AXES) spd = last_fast_req[ax];
            else if (r < 80) spd = int'($urandom_range(400)) - 200;
            else spd = $signed(16'($urandom));
            if (spd == 0) spd = 1;
            if ($urandom_range(99) >= 10) gear = 0;
            if (ax < AXES) last_fast_req[ax] = spd;
         end else begin
            spd = 0;
            if (r < 85) gear = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 12));
         end
      end else if (pick < 82) op = OP_TICK;
      else if (pick < 93) op = OP_STOP;
      else op = OP_STOP_ALL;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      send_command(op, ax, spd, gear, link, gap);
   endtask

   initial begin
      int idle_plan[4];
      idle_plan = '{0, 88, 0, 33};
      sb = new();
      taken = 0;
      for (int i = 0; i < AXES; i++) last_fast_req[i] = 1;
      reset             = 1'b1;
      csr_write         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      start             = 1'b0;
      req_operation     = OP_TICK;
      req_axis_index    = '0;
      req_speed_request = '0;
      req_gear_request  = '0;
      req_link_up       = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass on reset register values
      send_command(OP_TICK, AXIS_PAN, 0, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_PAN, 32767, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_PAN, 32767, 0, 1'b1, 0);      // same speed, renew only
      send_command(OP_SET, AXIS_TILT, -32768, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_ROTATE, 0, -128, 1'b1, 0);
      send_command(OP_SET, AXIS_ROTATE, 0, 127, 1'b1, 0);     // gear change re-press
      send_command(OP_TICK, AXIS_PAN, -1, -1, 1'b1, 0);
      send_command(OP_SET, AXIS_PAN, 0, 1, 1'b1, 0);          // fast to slow
      send_command(OP_SET, AXIS_ROTATE, 1, 0, 1'b1, 0);       // slow to fast
      send_command(OP_SET, 2'd3, 5, 0, 1'b1, 0);              // bad axis
      send_command(OP_STOP, 2'd3, 0, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_TILT, 50, 0, 1'b0, 0);        // rejected, link down
      send_command(OP_SET, AXIS_TILT, 0, 0, 1'b0, 0);         // zero request stops
      send_command(OP_TICK, AXIS_TILT, 16'h5555, 8'h55, 1'b1, 0);
      send_command(OP_STOP, AXIS_PAN, 16'hAAAA, 8'hAA, 1'b0, 0);
      send_command(OP_STOP_ALL, 2'd3, 0, 0, 1'b0, 0);
      send_command(OP_SET, AXIS_PAN, -1, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_TILT, 0, -1, 1'b1, 0);
      send_command(OP_SET, AXIS_ROTATE, 300, 7, 1'b1, 0);     // both set, fast wins
      send_command(OP_TICK, AXIS_PAN, 0, 0, 1'b0, 0);         // link down clears all
      send_command(OP_TICK, AXIS_PAN, 0, 0, 1'b1, 0);
      send_command(OP_SET, AXIS_PAN, 16'h7FFF, 0, 1'b1, 0);
      send_command(OP_STOP_ALL, AXIS_PAN, 0, 0, 1'b1, 0);

      // random phases, each on its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: program_regs(0, 32767, 1, 127, 65535, 1);
            1: program_regs(600, 200, 9, 3, 0, 0);       // floors above ceilings, zero counts
            2: program_regs(0, 0, 1, 1, 1, 65535);       // clamped speed of zero
            3: program_regs(32767, 32767, 127, 127, 12, 3);
            default: program_regs($urandom_range(0, 300), $urandom_range(0, 400),
                                  $urandom_range(1, 127), $urandom_range(1, 127),
                                  $urandom_range(1, 25), $urandom_range(1, 12));
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) random_command(idle_plan[ph % 4]);
      end
      drain();

      $display("covered %0d commands, %0d outputs checked, %0d frames", sb.commands,
               sb.checked, sb.frames);
      $display("lease expiries %0d, fast repeats %0d, mismatches %0d", sb.expiries,
               sb.repeats, sb.errors);
      if (sb.errors == 0 && sb.outstanding() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
